/* hw/rtl/nnst_pkg.sv */
// ----------------------------------------------------------------------------
// nnst_pkg
// Shared constants, codes and controller/datapath signal groups for the
// nearest-neighbor step block.
// ----------------------------------------------------------------------------
package nnst_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int COORD_W  = 32;
  localparam int SLOT_W   = 7;
  localparam int ACT_W    = 8;
  localparam int STEP_W   = 31;
  localparam int EXCL_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int DIFF_W   = COORD_W + 1;       // |d| magnitude
  localparam int SQ_W     = 2 * DIFF_W;        // one square
  localparam int D2_W     = SQ_W;              // sum of three squares
  localparam int ROOT_W   = 50;                // floor(sqrt(D2 * 2^32))
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int RREM_W   = ROOT_W + 2;
  localparam int PROD_W   = DIFF_W + STEP_W;
  localparam int DVD_W    = PROD_W + 16;
  localparam int QUO_W    = 32;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_MOVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXCL   = 2'd2;

  localparam logic [ACT_W-1:0]  ACTIVE_RST = 8'd100;
  localparam logic [STEP_W-1:0] STEP_RST   = 31'd66;
  localparam logic [EXCL_W-1:0] EXCL_RST   = 31'd65536;

  typedef struct packed {
    logic load;
    logic capture;
    logic issue;
    logic kept_pass;
    logic root_start;
    logic mul;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic dir_zero;
    logic root_busy;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/nnst_if.sv */
// ----------------------------------------------------------------------------
// nnst_if
// Valid/ready channels of the nearest-neighbor step block.
// ----------------------------------------------------------------------------
interface nnst_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [6:0]  slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  modport source (output valid, func, slot, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, func, slot, coord_x, coord_y, coord_z, output ready);
endinterface

interface nnst_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] moved_x;
  logic signed [31:0] moved_y;
  logic signed [31:0] moved_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic        found_new;
  modport source (output valid, moved_x, moved_y, moved_z, target_x, target_y, target_z,
                  found_new, input ready);
  modport sink (input valid, moved_x, moved_y, moved_z, target_x, target_y, target_z,
                found_new, output ready);
endinterface

interface nnst_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [31:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

/* hw/rtl/nnst_ctrl.sv */
// ----------------------------------------------------------------------------
// nnst_ctrl
// Sequencer: load, scan, length pass, square root, multiply, divide, deliver.
// ----------------------------------------------------------------------------
module nnst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_ready,
  input  nnst_pkg::stat_t st,
  output nnst_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == nnst_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (st.scan_done) state_next = S_FLUSH;
        else cmd.issue = 1'b1;
      end
      S_FLUSH: begin
        if (!st.pipe_busy) begin
          cmd.kept_pass = 1'b1;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (!st.pipe_busy) begin
          if (st.dir_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.root_start = 1'b1;
            state_next = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (!st.root_busy) begin
          cmd.mul = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!st.div_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* hw/rtl/nnst_dp.sv */
// ----------------------------------------------------------------------------
// nnst_dp
// Point table, distance pipeline, nearest search, square root, dividers,
// output register and configuration registers.
// ----------------------------------------------------------------------------
module nnst_dp #(
  parameter int TABLE_DEPTH = nnst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nnst_pkg::cmd_t       cmd,
  output nnst_pkg::stat_t      st,
  input  logic [6:0]           slot,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  input  logic signed [31:0]   coord_z,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_idx,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   moved_x,
  output logic signed [31:0]   moved_y,
  output logic signed [31:0]   moved_z,
  output logic signed [31:0]   target_x,
  output logic signed [31:0]   target_y,
  output logic signed [31:0]   target_z,
  output logic                 found_new
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int CWD = nnst_pkg::COORD_W;
  localparam int DW = nnst_pkg::DIFF_W;

  // configuration
  logic [nnst_pkg::ACT_W-1:0]  active;
  logic [nnst_pkg::STEP_W-1:0] step;
  logic [nnst_pkg::EXCL_W-1:0] excl;
  logic [2*nnst_pkg::EXCL_W-1:0] excl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= nnst_pkg::ACTIVE_RST;
      step   <= nnst_pkg::STEP_RST;
      excl   <= nnst_pkg::EXCL_RST;
    end else if (cfg_valid) begin
      case (cfg_idx)
        nnst_pkg::REG_ACTIVE: active <= cfg_data[nnst_pkg::ACT_W-1:0];
        nnst_pkg::REG_STEP:   step   <= cfg_data[nnst_pkg::STEP_W-1:0];
        nnst_pkg::REG_EXCL:   excl   <= cfg_data[nnst_pkg::EXCL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) excl2 <= excl * excl;

  // table
  logic [3*CWD-1:0] mem [TABLE_DEPTH];
  logic [3*CWD-1:0] rd_word;
  logic [CW-1:0]    idx, n_lim;
  logic             slot_ok;

  assign slot_ok = 32'(slot) < 32'(TABLE_DEPTH);
  assign n_lim = (32'(active) >= 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(active);

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) mem[AW'(slot)] <= {coord_z, coord_y, coord_x};
  end

  always_ff @(posedge clk) rd_word <= mem[idx[AW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.capture) idx <= '0;
    else if (cmd.issue) idx <= idx + CW'(1);
  end

  // query and kept point
  logic [CWD-1:0] qp [3];
  logic [CWD-1:0] kept [3];
  logic           found;
  logic [nnst_pkg::D2_W-1:0] best;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qp[0] <= coord_x;
      qp[1] <= coord_y;
      qp[2] <= coord_z;
    end
  end

  // distance pipeline
  logic v1, v2, v3, v4, kp1, kp2, kp3, kp4;
  logic [CWD-1:0] p1 [3];
  logic [CWD-1:0] p2 [3];
  logic [CWD-1:0] p3 [3];
  logic [CWD-1:0] p4 [3];
  logic [DW-1:0]  m2 [3];
  logic [DW-1:0]  m3 [3];
  logic [DW-1:0]  m4 [3];
  logic           s2 [3];
  logic           s3 [3];
  logic           s4 [3];
  logic [nnst_pkg::SQ_W-1:0] sq3 [3];
  logic [nnst_pkg::D2_W-1:0] sum4;
  logic [DW-1:0]  diff [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p1[a] = kp1 ? kept[a] : rd_word[a*CWD +: CWD];
      diff[a] = {p1[a][CWD-1], p1[a]} - {qp[a][CWD-1], qp[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue | cmd.kept_pass;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    kp1 <= cmd.kept_pass;
    kp2 <= kp1;
    kp3 <= kp2;
    kp4 <= kp3;
    for (int a = 0; a < 3; a++) begin
      p2[a] <= p1[a];
      s2[a] <= diff[a][DW-1];
      m2[a] <= diff[a][DW-1] ? -diff[a] : diff[a];
      p3[a] <= p2[a];
      s3[a] <= s2[a];
      m3[a] <= m2[a];
      sq3[a] <= m2[a] * m2[a];
      p4[a] <= p3[a];
      s4[a] <= s3[a];
      m4[a] <= m3[a];
    end
    sum4 <= sq3[0] + sq3[1] + sq3[2];
  end

  // search and length pass
  logic [nnst_pkg::D2_W-1:0] len_d2;
  logic [DW-1:0] dmag [3];
  logic          dsgn [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      for (int a = 0; a < 3; a++) kept[a] <= '0;
    end else if (cmd.capture) begin
      found <= 1'b0;
    end else if (v4 && !kp4) begin
      if ((nnst_pkg::D2_W'(excl2) < sum4) && (!found || sum4 < best)) begin
        found <= 1'b1;
        for (int a = 0; a < 3; a++) kept[a] <= p4[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && !kp4 && (nnst_pkg::D2_W'(excl2) < sum4) && (!found || sum4 < best))
      best <= sum4;
    if (v4 && kp4) begin
      len_d2 <= sum4;
      for (int a = 0; a < 3; a++) begin
        dmag[a] <= m4[a];
        dsgn[a] <= s4[a];
      end
    end
  end

  // square root, two radicand bits per cycle
  logic [nnst_pkg::RAD_W-1:0]  rad;
  logic [nnst_pkg::RREM_W-1:0] rrem;
  logic [nnst_pkg::ROOT_W-1:0] root;
  logic [nnst_pkg::ROOT_CNT_W-1:0] rcnt;
  logic rbusy;
  logic [nnst_pkg::RREM_W+1:0] rt, rtrial;

  assign rt = {rrem, rad[nnst_pkg::RAD_W-1 -: 2]};
  assign rtrial = (nnst_pkg::RREM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
    end else if (cmd.root_start) begin
      rbusy <= 1'b1;
    end else if (rbusy && rcnt == nnst_pkg::ROOT_CNT_W'(1)) begin
      rbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rad  <= nnst_pkg::RAD_W'({len_d2, 32'b0});
      rrem <= '0;
      root <= '0;
      rcnt <= nnst_pkg::ROOT_CNT_W'(nnst_pkg::ROOT_W);
    end else if (rbusy) begin
      rad  <= rad << 2;
      rcnt <= rcnt - nnst_pkg::ROOT_CNT_W'(1);
      if (rt >= rtrial) begin
        rrem <= nnst_pkg::RREM_W'(rt - rtrial);
        root <= {root[nnst_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rrem <= nnst_pkg::RREM_W'(rt);
        root <= {root[nnst_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // scale and divide, one quotient bit per cycle on each axis
  logic [nnst_pkg::PROD_W-1:0] prod [3];
  logic [nnst_pkg::DVD_W-1:0]  dvd [3];
  logic [nnst_pkg::ROOT_W-1:0] drem [3];
  logic [nnst_pkg::QUO_W-1:0]  quo [3];
  logic [nnst_pkg::ROOT_W:0]   dt [3];
  logic [nnst_pkg::DIV_CNT_W-1:0] dcnt;
  logic dbusy;

  always_comb begin
    for (int a = 0; a < 3; a++) dt[a] = {drem[a], dvd[a][nnst_pkg::DVD_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
    end else if (dbusy && dcnt == nnst_pkg::DIV_CNT_W'(1)) begin
      dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) dcnt <= nnst_pkg::DIV_CNT_W'(nnst_pkg::DVD_W);
    else if (dbusy) dcnt <= dcnt - nnst_pkg::DIV_CNT_W'(1);
    for (int a = 0; a < 3; a++) begin
      if (cmd.mul) prod[a] <= dmag[a] * step;
      if (cmd.capture) begin
        quo[a] <= '0;
      end else if (cmd.div_start) begin
        dvd[a]  <= {prod[a], 16'b0};
        drem[a] <= '0;
        quo[a]  <= '0;
      end else if (dbusy) begin
        dvd[a] <= dvd[a] << 1;
        if (dt[a] >= {1'b0, root}) begin
          drem[a] <= nnst_pkg::ROOT_W'(dt[a] - {1'b0, root});
          quo[a]  <= {quo[a][nnst_pkg::QUO_W-2:0], 1'b1};
        end else begin
          drem[a] <= nnst_pkg::ROOT_W'(dt[a]);
          quo[a]  <= {quo[a][nnst_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // step and saturate
  logic [CWD+1:0] mext [3];
  logic [CWD+1:0] nsum [3];
  logic [CWD-1:0] nsat [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mext[a] = {2'b00, quo[a]};
      nsum[a] = {{2{qp[a][CWD-1]}}, qp[a]} + (dsgn[a] ? -mext[a] : mext[a]);
      if (nsum[a][CWD+1:CWD-1] == 3'b000 || nsum[a][CWD+1:CWD-1] == 3'b111)
        nsat[a] = nsum[a][CWD-1:0];
      else if (nsum[a][CWD+1])
        nsat[a] = {1'b1, {(CWD-1){1'b0}}};
      else
        nsat[a] = {1'b0, {(CWD-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      moved_x   <= nsat[0];
      moved_y   <= nsat[1];
      moved_z   <= nsat[2];
      target_x  <= kept[0];
      target_y  <= kept[1];
      target_z  <= kept[2];
      found_new <= found;
    end
  end

  assign st.scan_done = (idx == n_lim);
  assign st.pipe_busy = v1 | v2 | v3 | v4;
  assign st.dir_zero  = (len_d2 == '0);
  assign st.root_busy = rbusy;
  assign st.div_busy  = dbusy;
  assign st.out_free  = !out_valid || out_ready;

endmodule

/* hw/rtl/nearest_neighbor_step_toward_top.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_step_toward_top
// Nearest-neighbor search over a 3D point table and one fixed-point step
// of the query point toward the neighbor found.
//
// in_ch carries load and move transactions. A load writes one table slot;
// loads may follow each other every cycle. A move scans active entries
// one per cycle through the distance pipe, runs one pass of the kept
// point through that pipe, a square root and three parallel dividers.
// A zero direction skips root and divide. One result transaction per move
// sits in an output register; the next transaction is accepted while it
// waits, and a move that finishes while out_ch is stalled holds until the
// register frees.
// cfg writes registers any cycle (ready always high); write only when idle.
// Reset clears the kept point to zero and restores register defaults;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_step_toward_top #(
  parameter int TABLE_DEPTH = nnst_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  nnst_in_if.sink      in_ch,
  nnst_out_if.source   out_ch,
  nnst_cfg_if.sink     cfg
);

  nnst_pkg::cmd_t  cmd;
  nnst_pkg::stat_t st;

  assign cfg.ready = 1'b1;

  nnst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  nnst_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .slot      (in_ch.slot),
    .coord_x   (in_ch.coord_x),
    .coord_y   (in_ch.coord_y),
    .coord_z   (in_ch.coord_z),
    .cfg_valid (cfg.valid),
    .cfg_idx   (cfg.idx),
    .cfg_data  (cfg.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .moved_x   (out_ch.moved_x),
    .moved_y   (out_ch.moved_y),
    .moved_z   (out_ch.moved_z),
    .target_x  (out_ch.target_x),
    .target_y  (out_ch.target_y),
    .target_z  (out_ch.target_z),
    .found_new (out_ch.found_new)
  );

endmodule

/* verif/nearest_neighbor_step_toward_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_step_toward_top_tb
// Self-checking bench for the nearest-neighbor step block. Load and move
// transactions come from a queue, with random gaps when enabled. An in-bench
// model of the table, the kept point and the Q15.16 step predicts each move
// result. The monitor stalls at random when enabled and compares every
// result field by field. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module nearest_neighbor_step_toward_top_tb;

  localparam int DEPTH      = nnst_pkg::TABLE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 500;

  typedef struct {
    logic              func;
    logic [6:0]        slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_txn_t;

  typedef struct {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic               found;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nnst_in_if  in_ch();
  nnst_out_if out_ch();
  nnst_cfg_if cfg_ch();

  nearest_neighbor_step_toward_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  point_txn_t   pending_q[$];
  step_result_t step_results_q[$];
  point_txn_t   cur_txn;

  logic signed [31:0] tbl_x[DEPTH], tbl_y[DEPTH], tbl_z[DEPTH];
  logic signed [31:0] hint_x[DEPTH], hint_y[DEPTH], hint_z[DEPTH];
  logic signed [31:0] kept_x, kept_y, kept_z;
  logic [nnst_pkg::ACT_W-1:0]   act_reg;
  logic [nnst_pkg::STEP_W-1:0]  step_reg;
  logic [nnst_pkg::EXCL_W-1:0]  excl_reg;

  int  errors = 0;
  int  src_gap = 0;
  int  snk_stall = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic logic [67:0] sq_dist(input logic signed [32:0] a,
                                          input logic signed [32:0] b,
                                          input logic signed [32:0] c);
    logic signed [67:0] ea, eb, ec;
    ea = a; eb = b; ec = c;
    if (ea < 0) ea = -ea;
    if (eb < 0) eb = -eb;
    if (ec < 0) ec = -ec;
    return ea * ea + eb * eb + ec * ec;
  endfunction

  function automatic logic [63:0] root_q32(input logic [67:0] d2);
    logic [127:0] x, t;
    logic [63:0]  r;
    x = {60'b0, d2} << 32;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'b0, r | (64'b1 << b)};
      if (t * t <= x) r = t[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] axis_move(input logic signed [32:0] d,
                                                    input logic [63:0] len);
    logic signed [127:0] ed;
    logic [127:0] num;
    logic [63:0]  m;
    ed = d;
    if (ed < 0) ed = -ed;
    num = (ed * {97'b0, step_reg}) << 16;
    m = 64'(num / {64'b0, len});
    return d < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic predict_step(input point_txn_t t);
    logic signed [32:0] dx, dy, dz;
    logic [67:0] d2, best, excl2, e;
    logic [63:0] len;
    logic signed [63:0] qx, qy, qz;
    logic found;
    int n;
    step_result_t r;
    if (t.func == nnst_pkg::FUNC_LOAD) begin
      tbl_x[t.slot] = t.x; tbl_y[t.slot] = t.y; tbl_z[t.slot] = t.z;
      return;
    end
    n = act_reg < DEPTH ? act_reg : DEPTH;
    e = excl_reg;
    excl2 = e * e;
    found = 1'b0;
    best = '0;
    for (int i = 0; i < n; i++) begin
      dx = tbl_x[i] - t.x; dy = tbl_y[i] - t.y; dz = tbl_z[i] - t.z;
      d2 = sq_dist(dx, dy, dz);
      if (d2 > excl2 && (!found || d2 < best)) begin
        found = 1'b1;
        best = d2;
        kept_x = tbl_x[i]; kept_y = tbl_y[i]; kept_z = tbl_z[i];
      end
    end
    qx = t.x; qy = t.y; qz = t.z;
    dx = kept_x - t.x; dy = kept_y - t.y; dz = kept_z - t.z;
    if (dx != 0 || dy != 0 || dz != 0) begin
      len = root_q32(sq_dist(dx, dy, dz));
      qx += axis_move(dx, len);
      qy += axis_move(dy, len);
      qz += axis_move(dz, len);
    end
    r.mx = sat32(qx); r.my = sat32(qy); r.mz = sat32(qz);
    r.tx = kept_x; r.ty = kept_y; r.tz = kept_z;
    r.found = found;
    step_results_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_step(cur_txn);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_txn = pending_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.func    <= cur_txn.func;
          in_ch.slot    <= cur_txn.slot;
          in_ch.coord_x <= cur_txn.x;
          in_ch.coord_y <= cur_txn.y;
          in_ch.coord_z <= cur_txn.z;
          src_gap = gaps_on ? $urandom_range(0, 12) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    step_result_t w;
    int n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_stall = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (step_results_q.size() == 0) begin
        report("unexpected transaction", out_ch.moved_x, 32'h0);
      end else begin
        w = step_results_q.pop_front();
        if (out_ch.moved_x !== w.mx) report("moved_x", out_ch.moved_x, w.mx);
        if (out_ch.moved_y !== w.my) report("moved_y", out_ch.moved_y, w.my);
        if (out_ch.moved_z !== w.mz) report("moved_z", out_ch.moved_z, w.mz);
        if (out_ch.target_x !== w.tx) report("target_x", out_ch.target_x, w.tx);
        if (out_ch.target_y !== w.ty) report("target_y", out_ch.target_y, w.ty);
        if (out_ch.target_z !== w.tz) report("target_z", out_ch.target_z, w.tz);
        if (out_ch.found_new !== w.found) report("found_new", out_ch.found_new, w.found);
      end
      n = gaps_on ? $urandom_range(0, 12) : 0;
      snk_stall = n;
      out_ch.ready <= (n == 0);
    end else if (snk_stall > 0) begin
      snk_stall--;
      out_ch.ready <= (snk_stall == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [nnst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      nnst_pkg::REG_ACTIVE: act_reg  = val[nnst_pkg::ACT_W-1:0];
      nnst_pkg::REG_STEP:   step_reg = val[nnst_pkg::STEP_W-1:0];
      nnst_pkg::REG_EXCL:   excl_reg = val[nnst_pkg::EXCL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] a, input logic [31:0] s, input logic [31:0] e);
    cfg_write(nnst_pkg::REG_ACTIVE, a);
    cfg_write(nnst_pkg::REG_STEP, s);
    cfg_write(nnst_pkg::REG_EXCL, e);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (step_results_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_txn(input logic f, input logic [6:0] s, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z);
    point_txn_t t;
    t.func = f; t.slot = s; t.x = x; t.y = y; t.z = z;
    if (f == nnst_pkg::FUNC_LOAD) begin
      hint_x[s] = x; hint_y[s] = y; hint_z[s] = z;
    end
    pending_q.push_back(t);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: case ($urandom_range(0, 4))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 32'sh0;
           3: return -32'sh1;
           default: return 32'sh1;
         endcase
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] jitter();
    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
  endfunction

  task automatic push_random(input int count);
    int s;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        push_txn(nnst_pkg::FUNC_LOAD, 7'($urandom), pick_coord(), pick_coord(),
                 pick_coord());
      end else if ($urandom_range(0, 1) == 0) begin
        s = $urandom_range(0, DEPTH - 1);
        push_txn(nnst_pkg::FUNC_MOVE, 7'($urandom), hint_x[s] + jitter(),
                 hint_y[s] + jitter(), hint_z[s] + jitter());
      end else begin
        push_txn(nnst_pkg::FUNC_MOVE, 7'($urandom), pick_coord(), pick_coord(),
                 pick_coord());
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.func = nnst_pkg::FUNC_LOAD; in_ch.slot = '0;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.idx = nnst_pkg::REG_ACTIVE; cfg_ch.data = '0;
    kept_x = '0; kept_y = '0; kept_z = '0;
    act_reg = nnst_pkg::ACTIVE_RST;
    step_reg = nnst_pkg::STEP_RST;
    excl_reg = nnst_pkg::EXCL_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // every slot loaded first so no search reads an empty entry
    push_txn(nnst_pkg::FUNC_LOAD, 7'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_txn(nnst_pkg::FUNC_LOAD, 7'd1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    for (int s = 2; s < DEPTH; s++)
      push_txn(nnst_pkg::FUNC_LOAD, 7'(s), pick_coord(), pick_coord(), pick_coord());
    push_txn(nnst_pkg::FUNC_MOVE, 7'd0, 32'sh0, 32'sh0, 32'sh0);
    push_txn(nnst_pkg::FUNC_MOVE, 7'h7f, hint_x[5], hint_y[5], hint_z[5]);
    push_txn(nnst_pkg::FUNC_MOVE, 7'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    push_txn(nnst_pkg::FUNC_MOVE, 7'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    push_txn(nnst_pkg::FUNC_MOVE, 7'd0, hint_x[9] + 32'sh8000, hint_y[9], hint_z[9]);
    drain();
    // query sitting on the kept point with nothing qualifying: zero direction
    set_regs(32'd0, 32'h7fffffff, 32'h7fffffff);
    push_txn(nnst_pkg::FUNC_MOVE, 7'd0, kept_x, kept_y, kept_z);
    drain();

    set_regs(32'd128, 32'h0001_0000, 32'd0);
    gaps_on = 1'b1;
    push_random(150);
    drain();
    push_random(150);
    drain();

    set_regs(32'd1, 32'd0, 32'd0);
    gaps_on = 1'b0;
    push_random(150);
    drain();

    set_regs(32'd0, 32'h7fffffff, 32'h0001_0000);
    gaps_on = 1'b1;
    push_random(150);
    drain();
    push_txn(nnst_pkg::FUNC_MOVE, 7'd0, kept_x, kept_y, kept_z);
    drain();

    set_regs(32'd255, 32'h0001_0000, 32'h7fffffff);
    push_random(200);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(1, 128), $urandom_range(0, 32'h0004_0000),
               $urandom_range(0, 32'h0002_0000));
      gaps_on = (p != 1);
      push_random(180);
      drain();
    end

    set_regs(32'd100, $urandom & 32'h7fffffff, $urandom & 32'h7fffffff);
    gaps_on = 1'b1;
    push_random(120);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && step_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/nnst_pkg.sv
hw/rtl/nnst_if.sv
hw/rtl/nnst_ctrl.sv
hw/rtl/nnst_dp.sv
hw/rtl/nearest_neighbor_step_toward_top.sv
verif/nearest_neighbor_step_toward_top_tb.sv
